### sv/kutt_pkg.sv
// ----------------------------------------------------------------------------
// kutt_pkg
// Types, codes and helper functions shared by the usage tally table files.
// ----------------------------------------------------------------------------
package kutt_pkg;

	// Opcodes of an input item
	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_SUMS   = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	// Status of a recorded item
	localparam logic [1:0] ST_AVAIL   = 2'd0;
	localparam logic [1:0] ST_UNAVAIL = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_IGNORE  = 2'd3;  // item is dropped

	// Result codes
	localparam logic [1:0] CODE_OK      = 2'd0;
	localparam logic [1:0] CODE_FULL    = 2'd1;
	localparam logic [1:0] CODE_NOMATCH = 2'd2;

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_SH_RD,
		S_SH_WR,
		S_INS,
		S_FIN
	} state_t;

	// One table slot
	typedef struct packed {
		logic [15:0] rank;
		logic [31:0] user;
		logic [31:0] ready_blocks;
		logic [31:0] missing_blocks;
		logic [31:0] ready_files;
		logic [31:0] missing_files;
		logic        unknown;
	} entry_t;

	// One result item
	typedef struct packed {
		logic [1:0]  code;
		logic [15:0] out_rank;
		logic [31:0] ready_blocks;
		logic [31:0] missing_blocks;
		logic [31:0] all_blocks;
		logic        unknown_seen;
		logic [31:0] grand_blocks;
		logic [31:0] grand_files;
		logic        last;
	} res_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? MAX32 : s[31:0];
	endfunction

	// Add one item to a slot according to its status
	function automatic entry_t apply_item(input entry_t e, input logic [30:0] blocks,
			input logic [1:0] status);
		entry_t r;
		r = e;
		if (status == ST_AVAIL) begin
			r.ready_blocks = sat_add32(e.ready_blocks, {1'b0, blocks});
			r.ready_files  = sat_add32(e.ready_files, 32'd1);
		end else if (status == ST_UNAVAIL) begin
			r.missing_blocks = sat_add32(e.missing_blocks, {1'b0, blocks});
			r.missing_files  = sat_add32(e.missing_files, 32'd1);
		end else begin
			r.unknown = 1'b1;
		end
		return r;
	endfunction

endpackage

### sv/kutt_req_if.sv
// ----------------------------------------------------------------------------
// kutt_req_if
// Input channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface kutt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] rank;
	logic [31:0] user_id;
	logic [30:0] block_count;
	logic [1:0]  item_status;

	modport source (output valid, opcode, rank, user_id, block_count, item_status,
		input ready);
	modport sink (input valid, opcode, rank, user_id, block_count, item_status,
		output ready);
endinterface

### sv/kutt_rsp_if.sv
// ----------------------------------------------------------------------------
// kutt_rsp_if
// Output channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface kutt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  code;
	logic [15:0] out_rank;
	logic [31:0] ready_blocks;
	logic [31:0] missing_blocks;
	logic [31:0] all_blocks;
	logic        unknown_seen;
	logic [31:0] grand_blocks;
	logic [31:0] grand_files;
	logic        last;

	modport source (output valid, code, out_rank, ready_blocks, missing_blocks,
		all_blocks, unknown_seen, grand_blocks, grand_files, last, input ready);
	modport sink (input valid, code, out_rank, ready_blocks, missing_blocks,
		all_blocks, unknown_seen, grand_blocks, grand_files, last, output ready);
endinterface

### sv/keyed_usage_tally_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_usage_tally_table_unit
// Sorted table of usage counters keyed by (rank, user), held in one memory.
// ----------------------------------------------------------------------------
// One item at a time is processed. The slots live in a single synchronous
// memory (one read, one write port, registered read data) and a sequencer
// walks them with a read state and an evaluate state per slot. A record that
// inserts shifts each later slot up, one read and one write per slot moved;
// clear and an ignored record skip the walk. Report results stall the walk
// while the output register is occupied; the next item is accepted while the
// last result of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
module keyed_usage_tally_table_unit #(
	parameter int ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	kutt_req_if.sink  req,
	kutt_rsp_if.source rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	kutt_pkg::state_t state_q, state_d;

	// Latched request
	logic [1:0]  op_q;
	logic [15:0] rank_q;
	logic [31:0] user_q;
	logic [30:0] blocks_q;
	logic [1:0]  status_q;

	logic [CW-1:0] used_q, cnt_q, pos_q;
	logic [31:0]   gb_q, gf_q;
	logic          pend_q;
	kutt_pkg::res_t pend_res_q, res_q, out_res_q;
	logic          out_valid_q;

	// Slot memory
	kutt_pkg::entry_t mem [ENTRIES];
	kutt_pkg::entry_t rd_entry_q;
	logic [IW-1:0]    mem_raddr, mem_waddr;
	logic             mem_we;
	kutt_pkg::entry_t mem_wdata;

	logic           emit;
	kutt_pkg::res_t emit_res;

	logic can_emit, scan_end, key_eq, key_after, user_hit, req_fire, tbl_full;
	logic [CW-1:0] cnt_dec;
	logic [33:0] gb_sum, gf_sum;
	kutt_pkg::entry_t new_entry;
	kutt_pkg::res_t hit_res, res_init, pend_last;

	assign req_fire = req.valid && req.ready;
	assign can_emit = !out_valid_q || rsp.ready;
	assign scan_end = (cnt_q == used_q);
	assign tbl_full = (used_q == CW'(ENTRIES));
	assign cnt_dec  = cnt_q - CW'(1);
	assign key_eq   = (rd_entry_q.rank == rank_q) && (rd_entry_q.user == user_q);
	assign key_after = (rd_entry_q.rank > rank_q) ||
		((rd_entry_q.rank == rank_q) && (rd_entry_q.user > user_q));
	assign user_hit = (rd_entry_q.user == user_q);
	assign gb_sum = {2'b0, gb_q} + {2'b0, rd_entry_q.ready_blocks} +
		{2'b0, rd_entry_q.missing_blocks};
	assign gf_sum = {2'b0, gf_q} + {2'b0, rd_entry_q.ready_files} +
		{2'b0, rd_entry_q.missing_files};

	// Fresh slot for an inserted key
	always_comb begin
		new_entry      = '0;
		new_entry.rank = rank_q;
		new_entry.user = user_q;
		new_entry      = kutt_pkg::apply_item(new_entry, blocks_q, status_q);
	end

	// Report result for the slot just read
	always_comb begin
		hit_res                = '0;
		hit_res.code           = kutt_pkg::CODE_OK;
		hit_res.out_rank       = rd_entry_q.rank;
		hit_res.ready_blocks   = rd_entry_q.ready_blocks;
		hit_res.missing_blocks = rd_entry_q.missing_blocks;
		hit_res.all_blocks     = kutt_pkg::sat_add32(rd_entry_q.ready_blocks,
			rd_entry_q.missing_blocks);
		hit_res.unknown_seen   = rd_entry_q.unknown;
	end

	// Starting result of an item, and the held report hit marked as final
	always_comb begin
		res_init       = '0;
		res_init.code  = kutt_pkg::CODE_OK;
		res_init.last  = 1'b1;
		pend_last      = pend_res_q;
		pend_last.last = 1'b1;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kutt_pkg::S_IDLE: begin
				if (req_fire) begin
					if (req.opcode == kutt_pkg::OP_CLEAR ||
							(req.opcode == kutt_pkg::OP_RECORD &&
							req.item_status == kutt_pkg::ST_IGNORE))
						state_d = kutt_pkg::S_FIN;
					else
						state_d = kutt_pkg::S_RD;
				end
			end
			kutt_pkg::S_RD: begin
				if (!scan_end)
					state_d = kutt_pkg::S_EV;
				else if (op_q == kutt_pkg::OP_RECORD && !tbl_full)
					state_d = kutt_pkg::S_SH_RD;
				else
					state_d = kutt_pkg::S_FIN;
			end
			kutt_pkg::S_EV: begin
				priority if (op_q == kutt_pkg::OP_RECORD && key_eq)
					state_d = kutt_pkg::S_FIN;
				else if (op_q == kutt_pkg::OP_RECORD && key_after)
					state_d = tbl_full ? kutt_pkg::S_FIN : kutt_pkg::S_SH_RD;
				else if (op_q == kutt_pkg::OP_REPORT && user_hit && pend_q && !can_emit)
					state_d = kutt_pkg::S_EV;
				else
					state_d = kutt_pkg::S_RD;
			end
			kutt_pkg::S_SH_RD: state_d = (cnt_q == pos_q) ? kutt_pkg::S_INS : kutt_pkg::S_SH_WR;
			kutt_pkg::S_SH_WR: state_d = kutt_pkg::S_SH_RD;
			kutt_pkg::S_INS:   state_d = kutt_pkg::S_FIN;
			kutt_pkg::S_FIN:   state_d = can_emit ? kutt_pkg::S_IDLE : kutt_pkg::S_FIN;
			default:           state_d = kutt_pkg::S_IDLE;
		endcase
	end

	// Memory control and result emission
	always_comb begin
		mem_raddr = cnt_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IW-1:0];
		mem_wdata = kutt_pkg::apply_item(rd_entry_q, blocks_q, status_q);
		emit      = 1'b0;
		emit_res  = res_q;
		unique case (state_q)
			kutt_pkg::S_EV: begin
				if (op_q == kutt_pkg::OP_RECORD && key_eq)
					mem_we = 1'b1;
				if (op_q == kutt_pkg::OP_REPORT && user_hit && pend_q && can_emit) begin
					emit     = 1'b1;
					emit_res = pend_res_q;
				end
			end
			kutt_pkg::S_SH_RD: mem_raddr = cnt_dec[IW-1:0];
			kutt_pkg::S_SH_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_entry_q;
			end
			kutt_pkg::S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[IW-1:0];
				mem_wdata = new_entry;
			end
			kutt_pkg::S_FIN: emit = can_emit;
			default: ;
		endcase
	end

	assign req.ready = (state_q == kutt_pkg::S_IDLE);

	// Slot memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_entry_q <= mem[mem_raddr];
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kutt_pkg::S_IDLE;
			used_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (state_q == kutt_pkg::S_IDLE && req_fire) begin
				pend_q <= 1'b0;
				if (req.opcode == kutt_pkg::OP_CLEAR)
					used_q <= '0;
			end
			if (state_q == kutt_pkg::S_EV && op_q == kutt_pkg::OP_REPORT && user_hit &&
					(!pend_q || can_emit))
				pend_q <= 1'b1;
			if (state_q == kutt_pkg::S_INS)
				used_q <= used_q + CW'(1);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (emit)
			out_res_q <= emit_res;
		unique case (state_q)
			kutt_pkg::S_IDLE: begin
				if (req_fire) begin
					op_q     <= req.opcode;
					rank_q   <= req.rank;
					user_q   <= req.user_id;
					blocks_q <= req.block_count;
					status_q <= req.item_status;
					cnt_q    <= '0;
					gb_q     <= '0;
					gf_q     <= '0;
					res_q    <= res_init;
				end
			end
			kutt_pkg::S_RD: begin
				if (scan_end) begin
					if (op_q == kutt_pkg::OP_RECORD) begin
						pos_q <= used_q;
						if (tbl_full)
							res_q.code <= kutt_pkg::CODE_FULL;
					end else if (op_q == kutt_pkg::OP_SUMS) begin
						res_q.grand_blocks <= gb_q;
						res_q.grand_files  <= gf_q;
					end else if (pend_q) begin
						res_q <= pend_last;
					end else begin
						res_q.code <= kutt_pkg::CODE_NOMATCH;
					end
				end
			end
			kutt_pkg::S_EV: begin
				if (op_q == kutt_pkg::OP_RECORD) begin
					if (!key_eq && key_after) begin
						// new key belongs here; a full table rejects it
						if (tbl_full) begin
							res_q.code <= kutt_pkg::CODE_FULL;
						end else begin
							pos_q <= cnt_q;
							cnt_q <= used_q;
						end
					end else if (!key_eq) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end else if (op_q == kutt_pkg::OP_SUMS) begin
					gb_q  <= (gb_sum[33:32] != 2'b0) ? kutt_pkg::MAX32 : gb_sum[31:0];
					gf_q  <= (gf_sum[33:32] != 2'b0) ? kutt_pkg::MAX32 : gf_sum[31:0];
					cnt_q <= cnt_q + CW'(1);
				end else if (!(user_hit && pend_q && !can_emit)) begin
					if (user_hit)
						pend_res_q <= hit_res;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			kutt_pkg::S_SH_WR: cnt_q <= cnt_dec;
			default: ;
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.code           = out_res_q.code;
	assign rsp.out_rank       = out_res_q.out_rank;
	assign rsp.ready_blocks   = out_res_q.ready_blocks;
	assign rsp.missing_blocks = out_res_q.missing_blocks;
	assign rsp.all_blocks     = out_res_q.all_blocks;
	assign rsp.unknown_seen   = out_res_q.unknown_seen;
	assign rsp.grand_blocks   = out_res_q.grand_blocks;
	assign rsp.grand_files    = out_res_q.grand_files;
	assign rsp.last           = out_res_q.last;

	// Checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(ENTRIES)) else $error("slot count beyond table size");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kutt_pkg::S_INS |-> used_q < CW'(ENTRIES))
		else $error("insert into full table");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q) else $error("emitted result not presented");

endmodule

### bench/keyed_usage_tally_table_unit_tb.sv
// ----------------------------------------------------------------------------
// keyed_usage_tally_table_unit_tb
// Self-checking bench for the usage tally table: a queue-fed driver sends
// records, clears, sums and reports in bursts, a monitor checks each result
// transfer against a behavioral copy of the sorted table.
// ----------------------------------------------------------------------------
module keyed_usage_tally_table_unit_tb;

	localparam int N = 16;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] rank;
		logic [31:0] user_id;
		logic [30:0] block_count;
		logic [1:0]  item_status;
	} req_t;

	logic clk;
	logic arst_n;

	kutt_req_if req();
	kutt_rsp_if rsp();

	keyed_usage_tally_table_unit #(.ENTRIES(N)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// shadow table
	kutt_pkg::entry_t tbl [N];
	int     used;

	req_t pending_items [$];
	kutt_pkg::res_t expected_results [$];
	int   errors;
	int   n_sent;
	int   n_checked;
	int   burst_left;
	int   gap_left;
	int   stall_phase;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Update shadow table and queue expected results for one accepted item
	task automatic tally_predict(input req_t it);
		kutt_pkg::res_t r;
		int     i;
		int     pos;
		int     hits;
		logic [63:0] wb;
		logic [63:0] wf;
		r = '0;
		r.last = 1'b1;
		case (it.opcode)
			kutt_pkg::OP_RECORD: begin
				if (it.item_status <= kutt_pkg::ST_UNKNOWN) begin
					for (i = 0; i < used; i++)
						if (tbl[i].rank == it.rank && tbl[i].user == it.user_id) break;
					if (i >= used) begin
						if (used >= N) begin
							r.code = kutt_pkg::CODE_FULL;
							i = -1;
						end else begin
							pos = 0;
							while (pos < used && !(tbl[pos].rank > it.rank ||
								(tbl[pos].rank == it.rank && tbl[pos].user > it.user_id)))
								pos++;
							for (int j = used; j > pos; j--) tbl[j] = tbl[j-1];
							tbl[pos] = '0;
							tbl[pos].rank = it.rank;
							tbl[pos].user = it.user_id;
							used++;
							i = pos;
						end
					end
					if (i >= 0) begin
						if (it.item_status == kutt_pkg::ST_AVAIL) begin
							tbl[i].ready_blocks = sat(tbl[i].ready_blocks, {1'b0, it.block_count});
							tbl[i].ready_files = sat(tbl[i].ready_files, 32'd1);
						end else if (it.item_status == kutt_pkg::ST_UNAVAIL) begin
							tbl[i].missing_blocks = sat(tbl[i].missing_blocks,
								{1'b0, it.block_count});
							tbl[i].missing_files = sat(tbl[i].missing_files, 32'd1);
						end else begin
							tbl[i].unknown = 1'b1;
						end
					end
				end
				expected_results.push_back(r);
			end
			kutt_pkg::OP_CLEAR: begin
				used = 0;
				expected_results.push_back(r);
			end
			kutt_pkg::OP_SUMS: begin
				wb = '0;
				wf = '0;
				for (i = 0; i < used; i++) begin
					wb += 64'(tbl[i].ready_blocks) + 64'(tbl[i].missing_blocks);
					wf += 64'(tbl[i].ready_files) + 64'(tbl[i].missing_files);
				end
				r.grand_blocks = (wb > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wb[31:0];
				r.grand_files = (wf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wf[31:0];
				expected_results.push_back(r);
			end
			default: begin
				hits = 0;
				for (i = 0; i < used; i++) begin
					if (tbl[i].user == it.user_id) begin
						r = '0;
						r.out_rank = tbl[i].rank;
						r.ready_blocks = tbl[i].ready_blocks;
						r.missing_blocks = tbl[i].missing_blocks;
						r.all_blocks = sat(tbl[i].ready_blocks, tbl[i].missing_blocks);
						r.unknown_seen = tbl[i].unknown;
						expected_results.push_back(r);
						hits++;
					end
				end
				if (hits == 0) begin
					r = '0;
					r.code = kutt_pkg::CODE_NOMATCH;
					r.last = 1'b1;
					expected_results.push_back(r);
				end else begin
					expected_results[$].last = 1'b1;
				end
			end
		endcase
	endtask

	// Driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= kutt_pkg::OP_RECORD;
			req.rank <= '0;
			req.user_id <= '0;
			req.block_count <= '0;
			req.item_status <= '0;
			burst_left <= 0;
			gap_left <= 0;
			n_sent <= 0;
		end else begin
			automatic req_t it;
			if (req.valid && req.ready) begin
				tally_predict({req.opcode, req.rank, req.user_id, req.block_count,
					req.item_status});
				n_sent <= n_sent + 1;
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					req.valid <= 1'b1;
					{req.opcode, req.rank, req.user_id, req.block_count,
						req.item_status} <= it;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern and result checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase <= 0;
			errors <= 0;
			n_checked <= 0;
		end else begin
			automatic kutt_pkg::res_t got;
			automatic kutt_pkg::res_t want;
			if (rsp.valid && rsp.ready) begin
				got = {rsp.code, rsp.out_rank, rsp.ready_blocks, rsp.missing_blocks,
					rsp.all_blocks, rsp.unknown_seen, rsp.grand_blocks,
					rsp.grand_files, rsp.last};
				n_checked <= n_checked + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transfer %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display({"%0t: mismatch expected code=%0d rank=%h rb=%h mb=%h",
							" ab=%h u=%b gb=%h gf=%h last=%b"},
							$time, want.code, want.out_rank, want.ready_blocks,
							want.missing_blocks, want.all_blocks, want.unknown_seen,
							want.grand_blocks, want.grand_files, want.last);
						$display({"%0t:          actual   code=%0d rank=%h rb=%h mb=%h",
							" ab=%h u=%b gb=%h gf=%h last=%b"},
							$time, got.code, got.out_rank, got.ready_blocks,
							got.missing_blocks, got.all_blocks, got.unknown_seen,
							got.grand_blocks, got.grand_files, got.last);
						errors <= errors + 1;
					end
				end
			end
			// stretches of full speed, then a choppy pattern
			stall_phase <= (stall_phase + 1) % 96;
			if (stall_phase < 32) rsp.ready <= 1'b1;
			else if (stall_phase < 64) rsp.ready <= ((stall_phase % 5) != 0);
			else rsp.ready <= ($urandom_range(2) != 0);
		end
	end

	function automatic req_t mk(input logic [1:0] op, input logic [15:0] rk,
			input logic [31:0] u, input logic [30:0] b, input logic [1:0] st);
		return {op, rk, u, b, st};
	endfunction

	// Stimulus
	initial begin
		int rounds;
		logic [31:0] users [4];
		arst_n = 1'b0;
		used = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		pending_items.push_back(mk(kutt_pkg::OP_REPORT, '0, 32'd7, '0,
			kutt_pkg::ST_AVAIL));  // empty report
		pending_items.push_back(mk(kutt_pkg::OP_SUMS, '0, '0, '0, kutt_pkg::ST_AVAIL));
		repeat (3)
			pending_items.push_back(mk(kutt_pkg::OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF,
				31'h7FFF_FFFF, kutt_pkg::ST_AVAIL));
		repeat (2)
			pending_items.push_back(mk(kutt_pkg::OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF,
				31'h7FFF_FFFF, kutt_pkg::ST_UNAVAIL));
		pending_items.push_back(mk(kutt_pkg::OP_RECORD, '0, 32'hFFFF_FFFF, '0,
			kutt_pkg::ST_UNKNOWN));  // new key unknown
		pending_items.push_back(mk(kutt_pkg::OP_RECORD, '0, '0, 31'h1234,
			kutt_pkg::ST_IGNORE));   // ignored status
		pending_items.push_back(mk(kutt_pkg::OP_REPORT, '0, 32'hFFFF_FFFF, '0,
			kutt_pkg::ST_AVAIL));
		pending_items.push_back(mk(kutt_pkg::OP_SUMS, '0, '0, '0, kutt_pkg::ST_AVAIL));
		for (int k = 0; k < 15; k++)  // fill the table, then overflow it
			pending_items.push_back(mk(kutt_pkg::OP_RECORD, 16'(15 - k), 32'd5, 31'(k),
				kutt_pkg::ST_AVAIL));
		pending_items.push_back(mk(kutt_pkg::OP_REPORT, '0, 32'd5, '0, kutt_pkg::ST_AVAIL));
		pending_items.push_back(mk(kutt_pkg::OP_CLEAR, '0, '0, '0, kutt_pkg::ST_AVAIL));
		pending_items.push_back(mk(kutt_pkg::OP_REPORT, '0, 32'd5, '0, kutt_pkg::ST_AVAIL));

		// random part: mostly records over a small key space
		rounds = 0;
		for (int k = 0; k < 4; k++) users[k] = $urandom;
		while (rounds < 120) begin
			automatic int sel = $urandom_range(99);
			automatic logic [1:0] op;
			automatic logic [15:0] rk;
			automatic logic [31:0] u;
			automatic logic [30:0] b;
			automatic logic [1:0] st;
			op = (sel < 62) ? kutt_pkg::OP_RECORD : (sel < 66) ? kutt_pkg::OP_CLEAR :
				(sel < 78) ? kutt_pkg::OP_SUMS : kutt_pkg::OP_REPORT;
			rk = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(7));
			u = ($urandom_range(6) == 0) ? $urandom : users[$urandom_range(3)];
			b = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(100));
			st = ($urandom_range(9) == 0) ? kutt_pkg::ST_IGNORE : 2'($urandom_range(2));
			pending_items.push_back(mk(op, rk, u, b, st));
			rounds++;
		end

		wait (pending_items.size() == 0);
		@(posedge clk);
		while (req.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("Sent %0d items, checked %0d result transfers, with table fill,",
			n_sent, n_checked);
		$display("saturation, ignored status, clears and empty reports.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
sv/kutt_pkg.sv
sv/kutt_req_if.sv
sv/kutt_rsp_if.sv
sv/keyed_usage_tally_table_unit.sv
bench/keyed_usage_tally_table_unit_tb.sv
